@@ src/two_axis_pd_motor_command_top_macros.svh @@
// Assertion macros for the two-axis PD motor command block.
// Included by the top level; needs nothing else.
`ifndef TWO_AXIS_PD_MOTOR_COMMAND_TOP_MACROS_SVH
`define TWO_AXIS_PD_MOTOR_COMMAND_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPMC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPMC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tpmc_pkg.sv @@
// Shared widths, register codes and types for the two-axis PD motor command block.
// No dependencies.
package tpmc_pkg;

    localparam int ERROR_WIDTH  = 12;
    localparam int DIFF_W       = ERROR_WIDTH + 1;
    localparam int PGAIN_W      = 4;
    localparam int DGAIN_W      = 8;
    localparam int MAG_W        = 8;
    localparam int PROD_P_W     = ERROR_WIDTH + PGAIN_W + 1;
    localparam int PROD_D_W     = DIFF_W + DGAIN_W + 1;
    localparam int DRIVE_W      = PROD_D_W + 1;
    localparam int CMD_W        = 12;
    localparam int DIR_BIT_POS  = 10;
    localparam int AXIS_BIT_POS = 11;

    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TILT_MIN_DRIVE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAN_MIN_DRIVE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DRIVE      = 3'd4;

    localparam logic [PGAIN_W-1:0] PROP_GAIN_RST      = 4'd2;
    localparam logic [DGAIN_W-1:0] DERIV_GAIN_RST     = 8'd10;
    localparam logic [MAG_W-1:0]   TILT_MIN_DRIVE_RST = 8'd45;
    localparam logic [MAG_W-1:0]   PAN_MIN_DRIVE_RST  = 8'd55;
    localparam logic [MAG_W-1:0]   MAX_DRIVE_RST      = 8'd255;

    localparam logic AXIS_PAN  = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    typedef struct packed {
        logic [PGAIN_W-1:0] prop_gain;
        logic [DGAIN_W-1:0] deriv_gain;
        logic [MAG_W-1:0]   tilt_min_drive;
        logic [MAG_W-1:0]   pan_min_drive;
        logic [MAG_W-1:0]   max_drive;
    } tpmc_cfg_t;

    // Captured sample plus its difference from the last sample on the same axis
    typedef struct packed {
        logic                          axis;
        logic signed [ERROR_WIDTH-1:0] err;
        logic signed [DIFF_W-1:0]      diff;
    } tpmc_stage_t;

endpackage

@@ src/tpmc_err_if.sv @@
// Error sample channel: valid/ready handshake with axis and signed error.
// Depends on tpmc_pkg.
interface tpmc_err_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   axis;
    logic signed [tpmc_pkg::ERROR_WIDTH-1:0] error_sample;

    modport source (output valid, output axis, output error_sample, input ready);
    modport sink   (input valid, input axis, input error_sample, output ready);
endinterface

@@ src/tpmc_cmd_if.sv @@
// Motor command channel: valid/ready handshake with packed command and its parts.
// Depends on tpmc_pkg.
interface tpmc_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tpmc_pkg::CMD_W-1:0]   command_word;
    logic [tpmc_pkg::MAG_W-1:0]   drive_magnitude;
    logic                         direction;

    modport source (output valid, output command_word, output drive_magnitude,
                    output direction, input ready);
    modport sink   (input valid, input command_word, input drive_magnitude,
                    input direction, output ready);
endinterface

@@ src/tpmc_regs.sv @@
// APB-style configuration registers for gains, minimum drives and drive limit.
// Depends on tpmc_pkg.
module tpmc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tpmc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tpmc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tpmc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output tpmc_pkg::tpmc_cfg_t             cfg
);
    import tpmc_pkg::*;

    tpmc_cfg_t            cfg_reg;
    tpmc_cfg_t            cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PROP_GAIN:      cfg_next.prop_gain      = pwdata[PGAIN_W-1:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = pwdata[DGAIN_W-1:0];
                REG_TILT_MIN_DRIVE: cfg_next.tilt_min_drive = pwdata[MAG_W-1:0];
                REG_PAN_MIN_DRIVE:  cfg_next.pan_min_drive  = pwdata[MAG_W-1:0];
                REG_MAX_DRIVE:      cfg_next.max_drive      = pwdata[MAG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROP_GAIN:      prdata = APB_DATA_W'(cfg_reg.prop_gain);
            REG_DERIV_GAIN:     prdata = APB_DATA_W'(cfg_reg.deriv_gain);
            REG_TILT_MIN_DRIVE: prdata = APB_DATA_W'(cfg_reg.tilt_min_drive);
            REG_PAN_MIN_DRIVE:  prdata = APB_DATA_W'(cfg_reg.pan_min_drive);
            REG_MAX_DRIVE:      prdata = APB_DATA_W'(cfg_reg.max_drive);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
            cfg_reg.tilt_min_drive <= TILT_MIN_DRIVE_RST;
            cfg_reg.pan_min_drive  <= PAN_MIN_DRIVE_RST;
            cfg_reg.max_drive      <= MAX_DRIVE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/tpmc_front.sv @@
// Input register: captures a sample, forms its difference against the last
// sample on that axis and keeps the per-axis history. Depends on tpmc_pkg, tpmc_err_if.
module tpmc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    tpmc_err_if.sink              err_in,
    input  logic                  take,
    output logic                  stage_valid,
    output tpmc_pkg::tpmc_stage_t stage
);
    import tpmc_pkg::*;

    logic                          valid_reg;
    logic                          valid_next;
    tpmc_stage_t                   stage_reg;
    logic signed [ERROR_WIDTH-1:0] prev_reg [2];
    logic signed [ERROR_WIDTH-1:0] prev_sel;
    logic                          accept;

    // Stage frees up in the same cycle its content moves on
    assign err_in.ready = !valid_reg || take;
    assign accept       = err_in.valid && err_in.ready;
    assign prev_sel     = prev_reg[err_in.axis];
    assign stage_valid  = valid_reg;
    assign stage        = stage_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                prev_reg[err_in.axis] <= err_in.error_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.axis <= err_in.axis;
            stage_reg.err  <= err_in.error_sample;
            stage_reg.diff <= DIFF_W'(err_in.error_sample) - DIFF_W'(prev_sel);
        end
    end

endmodule

@@ src/tpmc_law.sv @@
// PD drive law with minimum-drive raise and clamp, packed into the result register.
// Depends on tpmc_pkg, tpmc_cmd_if.
module tpmc_law (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  stage_valid,
    input  tpmc_pkg::tpmc_stage_t stage,
    input  tpmc_pkg::tpmc_cfg_t   cfg,
    output logic                  take,
    tpmc_cmd_if.source            cmd_out
);
    import tpmc_pkg::*;

    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       drive_neg;
    logic [DRIVE_W-1:0]         mag_abs;
    logic [DRIVE_W-1:0]         min_ext;
    logic [DRIVE_W-1:0]         mag_raised;
    logic [MAG_W-1:0]           min_sel;
    logic [MAG_W-1:0]           mag_final;
    logic                       final_neg;
    logic                       dir;
    logic [CMD_W-1:0]           word;

    logic                       valid_reg;
    logic                       valid_next;
    logic [CMD_W-1:0]           word_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       dir_reg;

    assign take = !valid_reg || cmd_out.ready;

    always_comb
    begin
        prod_p    = $signed({1'b0, cfg.prop_gain}) * $signed(stage.err);
        prod_d    = $signed({1'b0, cfg.deriv_gain}) * $signed(stage.diff);
        drive     = DRIVE_W'(prod_p) + DRIVE_W'(prod_d);
        drive_neg = drive[DRIVE_W-1];
        mag_abs   = drive_neg ? DRIVE_W'(-drive) : DRIVE_W'(drive);

        min_sel = (stage.axis == AXIS_TILT) ? cfg.tilt_min_drive : cfg.pan_min_drive;
        min_ext = DRIVE_W'(min_sel);

        // Raise a small nonzero drive to the axis minimum, then clamp to the limit
        if (mag_abs != '0 && mag_abs < min_ext)
        begin
            mag_raised = min_ext;
        end
        else
        begin
            mag_raised = mag_abs;
        end

        if (mag_raised > DRIVE_W'(cfg.max_drive))
        begin
            mag_final = cfg.max_drive;
        end
        else
        begin
            mag_final = mag_raised[MAG_W-1:0];
        end

        // A drive clamped to zero counts as non-negative
        final_neg = drive_neg && (mag_final != '0);
        dir       = (stage.axis == AXIS_TILT) ? !final_neg : final_neg;
        word      = CMD_W'(mag_final)
                  | (CMD_W'(dir) << DIR_BIT_POS)
                  | (CMD_W'(stage.axis) << AXIS_BIT_POS);
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = stage_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stage_valid)
        begin
            word_reg <= word;
            mag_reg  <= mag_final;
            dir_reg  <= dir;
        end
    end

    assign cmd_out.valid           = valid_reg;
    assign cmd_out.command_word    = word_reg;
    assign cmd_out.drive_magnitude = mag_reg;
    assign cmd_out.direction       = dir_reg;

endmodule

@@ src/two_axis_pd_motor_command_top.sv @@
// Top level of the two-axis PD motor command block.
// Depends on tpmc_pkg, tpmc_err_if, tpmc_cmd_if, tpmc_regs, tpmc_front, tpmc_law.
//
//  channel   dir   handshake          payload
//  err_in    in    valid/ready        axis, error_sample
//  cmd_out   out   valid/ready        command_word, drive_magnitude, direction
//  apb       in    psel/penable/rdy   paddr, pwdata -> prdata
//
// One sample per cycle sustained while cmd_out is ready; a sample passes through the input
// register, then the PD law into the result register, before cmd_out valid rises and the
// output transfer can take place.
// The per-axis error history lives in the input stage and updates at each transfer.
// rst_n clears both stages, the history and the registers to their defaults.
// A stall on cmd_out backs up one stage at a time; err_in drops ready only when
// both registers are full.
`include "two_axis_pd_motor_command_top_macros.svh"

module two_axis_pd_motor_command_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tpmc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tpmc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tpmc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    tpmc_err_if.sink                        err_in,
    tpmc_cmd_if.source                      cmd_out
);
    import tpmc_pkg::*;

    tpmc_cfg_t          cfg;
    tpmc_stage_t        stage;
    logic               stage_valid;
    logic               take;
    logic               in_stall;
    logic               out_stall;
    logic               word_ok;
    logic               pg_write;
    logic [PGAIN_W-1:0] pg_data;
    logic [PGAIN_W-1:0] pg_now;

    tpmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpmc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .err_in      (err_in),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    tpmc_law u_law (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .cfg         (cfg),
        .take        (take),
        .cmd_out     (cmd_out)
    );

    assign in_stall  = !err_in.ready;
    assign out_stall = cmd_out.valid && !cmd_out.ready;
    assign word_ok   = (cmd_out.command_word[MAG_W-1:0] == cmd_out.drive_magnitude)
                    && (cmd_out.command_word[DIR_BIT_POS] == cmd_out.direction)
                    && (cmd_out.command_word[DIR_BIT_POS-1:MAG_W] == '0);
    assign pg_write  = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_PROP_GAIN);
    assign pg_data   = pwdata[PGAIN_W-1:0];
    assign pg_now    = cfg.prop_gain;

    `TPMC_ASSERT_SAME(a_ready_only_on_full, clk, rst_n, in_stall, out_stall, "early input stall")
    `TPMC_ASSERT_SAME(a_word_matches_fields, clk, rst_n, cmd_out.valid, word_ok, "word vs fields")
    `TPMC_ASSERT_NEXT(a_pg_write, clk, rst_n, pg_write, pg_now == $past(pg_data), "gain write lost")

endmodule
